// File: rtl/wvs_pkg.sv
// wvs_pkg: shared types, constants and the per-weight multiply schedule
// of the weighted vertex skinning block; no dependencies
package wvs_pkg;

  localparam int unsigned JOINT_DEPTH        = 64;
  localparam int unsigned WEIGHT_DEPTH       = 1024;
  localparam int unsigned MAX_VERTEX_WEIGHTS = 16;
  localparam int unsigned JA_W = $clog2(JOINT_DEPTH);
  localparam int unsigned WA_W = $clog2(WEIGHT_DEPTH);
  localparam int unsigned JOINT_W  = 160;
  localparam int unsigned WEIGHT_W = 117;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd26;

  typedef enum logic [1:0] {
    REQ_JOINT  = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_SKIN   = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_W,
    S_RD_J,
    S_MAC,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    X_PX, X_PY, X_PZ, X_TW, X_TX, X_TY, X_TZ, X_RX, X_RY, X_RZ
  } xsel_e;

  typedef enum logic [2:0] {
    Y_QX, Y_QY, Y_QZ, Y_QW, Y_B
  } ysel_e;

  typedef enum logic [3:0] {
    C_TW, C_TX, C_TY, C_TZ, C_RX, C_RY, C_RZ, C_AX, C_AY, C_AZ
  } comp_e;

  typedef struct packed {
    comp_e comp;
    xsel_e xsel;
    ysel_e ysel;
    logic  neg;
    logic  last;
  } uop_t;

  function automatic uop_t uop(input logic [STEP_W-1:0] s);
    uop_t u;
    case (s)
      5'd0:  u = '{C_TW, X_PX, Y_QX, 1'b1, 1'b0};
      5'd1:  u = '{C_TW, X_PY, Y_QY, 1'b1, 1'b0};
      5'd2:  u = '{C_TW, X_PZ, Y_QZ, 1'b1, 1'b1};
      5'd3:  u = '{C_TX, X_PX, Y_QW, 1'b0, 1'b0};
      5'd4:  u = '{C_TX, X_PY, Y_QZ, 1'b0, 1'b0};
      5'd5:  u = '{C_TX, X_PZ, Y_QY, 1'b1, 1'b1};
      5'd6:  u = '{C_TY, X_PX, Y_QZ, 1'b1, 1'b0};
      5'd7:  u = '{C_TY, X_PY, Y_QW, 1'b0, 1'b0};
      5'd8:  u = '{C_TY, X_PZ, Y_QX, 1'b0, 1'b1};
      5'd9:  u = '{C_TZ, X_PX, Y_QY, 1'b0, 1'b0};
      5'd10: u = '{C_TZ, X_PY, Y_QX, 1'b1, 1'b0};
      5'd11: u = '{C_TZ, X_PZ, Y_QW, 1'b0, 1'b1};
      5'd12: u = '{C_RX, X_TX, Y_QW, 1'b0, 1'b0};
      5'd13: u = '{C_RX, X_TW, Y_QX, 1'b1, 1'b0};
      5'd14: u = '{C_RX, X_TZ, Y_QY, 1'b1, 1'b0};
      5'd15: u = '{C_RX, X_TY, Y_QZ, 1'b0, 1'b1};
      5'd16: u = '{C_RY, X_TY, Y_QW, 1'b0, 1'b0};
      5'd17: u = '{C_RY, X_TZ, Y_QX, 1'b0, 1'b0};
      5'd18: u = '{C_RY, X_TW, Y_QY, 1'b1, 1'b0};
      5'd19: u = '{C_RY, X_TX, Y_QZ, 1'b1, 1'b1};
      5'd20: u = '{C_RZ, X_TZ, Y_QW, 1'b0, 1'b0};
      5'd21: u = '{C_RZ, X_TY, Y_QX, 1'b1, 1'b0};
      5'd22: u = '{C_RZ, X_TX, Y_QY, 1'b0, 1'b0};
      5'd23: u = '{C_RZ, X_TW, Y_QZ, 1'b1, 1'b1};
      5'd24: u = '{C_AX, X_RX, Y_B,  1'b0, 1'b1};
      5'd25: u = '{C_AY, X_RY, Y_B,  1'b0, 1'b1};
      5'd26: u = '{C_AZ, X_RZ, Y_B,  1'b0, 1'b1};
      default: u = '{C_TW, X_PX, Y_QX, 1'b0, 1'b0};
    endcase
    return u;
  endfunction

endpackage

// File: rtl/weighted_vertex_skinning.sv
// weighted_vertex_skinning: top level, joint and weight tables in wvs_ram,
// one shared multiply-accumulate unit; depends on wvs_pkg and wvs_ram
//
// Usage: one input channel (in_valid_i / in_stall_o) carries requests, one
// output channel (out_valid_o / out_stall_i) carries skinned vertices.
// A joint or weight write gives no output.
// A skin request walks its weights one at a time; each weight takes two
// table reads and 27 multiply-accumulate steps on the single 39x17 bit
// multiplier; a range error or a zero weight count goes straight to output.
// The block takes a new request only while no skin transaction is in work.
// Results sit in an output register; a write may be accepted while a result
// waits, and a finished vertex waits in its last state until the register
// frees up, so a stalling receiver holds the block without losing data.
// Reset clears the control state only; table contents are undefined until
// written.
module weighted_vertex_skinning (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [9:0]         entry_index_i,
  input  logic [5:0]         joint_ref_i,
  input  logic [4:0]         weight_count_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [15:0] rot_x_i,
  input  logic signed [15:0] rot_y_i,
  input  logic signed [15:0] rot_z_i,
  input  logic signed [15:0] rot_w_i,
  input  logic [14:0]        bias_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [1:0]         status_o
);

  wvs_pkg::state_e state_q, state_d;
  logic accept;
  logic [wvs_pkg::JOINT_W-1:0]  jrd;
  logic [wvs_pkg::WEIGHT_W-1:0] wrd;
  logic [9:0] widx_q;
  logic [4:0] rem_q;
  logic [wvs_pkg::STEP_W-1:0] step_q;
  logic err_q;
  logic [4:0] cnt;
  logic [10:0] wend;
  logic range_bad;
  logic joint_bad;

  logic signed [59:0] acc_q;
  logic signed [34:0] tw_q, tx_q, ty_q, tz_q;
  logic signed [38:0] rx_q, ry_q, rz_q;
  logic signed [43:0] ax_q, ay_q, az_q;

  wvs_pkg::uop_t u;
  wvs_pkg::uop_t nu;
  wvs_pkg::comp_e ncomp;
  logic signed [38:0] xop;
  logic signed [16:0] yop;
  logic signed [55:0] prod;
  logic signed [59:0] sum;
  logic signed [45:0] res;
  logic signed [59:0] init;

  logic signed [15:0] qx, qy, qz, qw;
  logic signed [31:0] ox, oy, oz, px, py, pz;
  logic [14:0] bw;
  logic [5:0] wj;

  logic sx, sy, sz;
  logic signed [31:0] cx, cy, cz;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != wvs_pkg::S_IDLE);

  assign cnt  = (weight_count_i > 5'(wvs_pkg::MAX_VERTEX_WEIGHTS)) ?
                5'(wvs_pkg::MAX_VERTEX_WEIGHTS) : weight_count_i;
  assign wend = {1'b0, entry_index_i} + {6'd0, cnt};
  assign range_bad = (wend > 11'(wvs_pkg::WEIGHT_DEPTH));

  // table layout
  assign qx = jrd[15:0];
  assign qy = jrd[31:16];
  assign qz = jrd[47:32];
  assign qw = jrd[63:48];
  assign ox = jrd[95:64];
  assign oy = jrd[127:96];
  assign oz = jrd[159:128];
  assign px = wrd[31:0];
  assign py = wrd[63:32];
  assign pz = wrd[95:64];
  assign bw = wrd[110:96];
  assign wj = wrd[116:111];
  assign joint_bad = ({1'b0, wj} >= 7'(wvs_pkg::JOINT_DEPTH));

  wvs_ram #(
    .WIDTH (wvs_pkg::JOINT_W),
    .DEPTH (wvs_pkg::JOINT_DEPTH)
  ) u_joint_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (req_type_i == wvs_pkg::REQ_JOINT) &&
              ({1'b0, entry_index_i} < 11'(wvs_pkg::JOINT_DEPTH))),
    .waddr_i (entry_index_i[wvs_pkg::JA_W-1:0]),
    .wdata_i ({vec_z_i, vec_y_i, vec_x_i, rot_w_i, rot_z_i, rot_y_i, rot_x_i}),
    .re_i    (state_q == wvs_pkg::S_RD_J),
    .raddr_i (wj[wvs_pkg::JA_W-1:0]),
    .rdata_o (jrd)
  );

  wvs_ram #(
    .WIDTH (wvs_pkg::WEIGHT_W),
    .DEPTH (wvs_pkg::WEIGHT_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (req_type_i == wvs_pkg::REQ_WEIGHT) &&
              ({1'b0, entry_index_i} < 11'(wvs_pkg::WEIGHT_DEPTH))),
    .waddr_i (entry_index_i[wvs_pkg::WA_W-1:0]),
    .wdata_i ({joint_ref_i, bias_i, vec_z_i, vec_y_i, vec_x_i}),
    .re_i    (state_q == wvs_pkg::S_RD_W),
    .raddr_i (widx_q[wvs_pkg::WA_W-1:0]),
    .rdata_o (wrd)
  );

  // multiply-accumulate datapath
  assign u     = wvs_pkg::uop(step_q);
  assign nu    = wvs_pkg::uop(step_q + 5'd1);
  assign ncomp = (step_q == wvs_pkg::LAST_STEP) ? wvs_pkg::C_TW : nu.comp;

  always_comb begin
    case (u.xsel)
      wvs_pkg::X_PX: xop = 39'(px);
      wvs_pkg::X_PY: xop = 39'(py);
      wvs_pkg::X_PZ: xop = 39'(pz);
      wvs_pkg::X_TW: xop = 39'(tw_q);
      wvs_pkg::X_TX: xop = 39'(tx_q);
      wvs_pkg::X_TY: xop = 39'(ty_q);
      wvs_pkg::X_TZ: xop = 39'(tz_q);
      wvs_pkg::X_RX: xop = rx_q;
      wvs_pkg::X_RY: xop = ry_q;
      wvs_pkg::X_RZ: xop = rz_q;
      default:       xop = '0;
    endcase
    case (u.ysel)
      wvs_pkg::Y_QX: yop = 17'(qx);
      wvs_pkg::Y_QY: yop = 17'(qy);
      wvs_pkg::Y_QZ: yop = 17'(qz);
      wvs_pkg::Y_QW: yop = 17'(qw);
      wvs_pkg::Y_B:  yop = $signed({2'b00, bw});
      default:       yop = '0;
    endcase
  end

  assign prod = xop * yop;
  assign sum  = acc_q + (u.neg ? -60'(prod) : 60'(prod));
  assign res  = 46'(sum >>> 14);

  // rounding constant plus a term that the shift carries through unchanged
  always_comb begin
    case (ncomp)
      wvs_pkg::C_RX: init = $signed({46'(ox), 14'd0}) + 60'sd8192;
      wvs_pkg::C_RY: init = $signed({46'(oy), 14'd0}) + 60'sd8192;
      wvs_pkg::C_RZ: init = $signed({46'(oz), 14'd0}) + 60'sd8192;
      wvs_pkg::C_AX: init = $signed({{2{ax_q[43]}}, ax_q, 14'd0}) + 60'sd8192;
      wvs_pkg::C_AY: init = $signed({{2{ay_q[43]}}, ay_q, 14'd0}) + 60'sd8192;
      wvs_pkg::C_AZ: init = $signed({{2{az_q[43]}}, az_q, 14'd0}) + 60'sd8192;
      default:       init = 60'sd8192;
    endcase
  end

  // saturation
  always_comb begin
    sx = (ax_q[43:31] != {13{ax_q[43]}});
    sy = (ay_q[43:31] != {13{ay_q[43]}});
    sz = (az_q[43:31] != {13{az_q[43]}});
    cx = sx ? (ax_q[43] ? 32'sh80000000 : 32'sh7fffffff) : ax_q[31:0];
    cy = sy ? (ay_q[43] ? 32'sh80000000 : 32'sh7fffffff) : ay_q[31:0];
    cz = sz ? (az_q[43] ? 32'sh80000000 : 32'sh7fffffff) : az_q[31:0];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      wvs_pkg::S_IDLE: begin
        if (accept && (req_type_i == wvs_pkg::REQ_SKIN)) begin
          state_d = (range_bad || (cnt == 5'd0)) ? wvs_pkg::S_DONE : wvs_pkg::S_RD_W;
        end
      end
      wvs_pkg::S_RD_W: state_d = wvs_pkg::S_RD_J;
      wvs_pkg::S_RD_J: state_d = joint_bad ? wvs_pkg::S_DONE : wvs_pkg::S_MAC;
      wvs_pkg::S_MAC: begin
        if (step_q == wvs_pkg::LAST_STEP) begin
          state_d = (rem_q == 5'd1) ? wvs_pkg::S_DONE : wvs_pkg::S_RD_W;
        end
      end
      wvs_pkg::S_DONE: begin
        if (!out_valid_o || !out_stall_i) begin
          state_d = wvs_pkg::S_IDLE;
        end
      end
      default: state_d = wvs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wvs_pkg::S_IDLE;
      out_valid_o <= 1'b0;
      step_q      <= '0;
      err_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == wvs_pkg::S_DONE && (!out_valid_o || !out_stall_i)) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == wvs_pkg::S_IDLE && accept) begin
        err_q  <= range_bad;
        step_q <= '0;
      end else if (state_q == wvs_pkg::S_RD_J) begin
        err_q  <= joint_bad;
        step_q <= '0;
      end else if (state_q == wvs_pkg::S_MAC) begin
        step_q <= (step_q == wvs_pkg::LAST_STEP) ? '0 : step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == wvs_pkg::S_IDLE && accept) begin
      widx_q <= entry_index_i;
      rem_q  <= cnt;
      ax_q   <= '0;
      ay_q   <= '0;
      az_q   <= '0;
    end
    if (state_q == wvs_pkg::S_RD_J) begin
      acc_q <= 60'sd8192;
    end
    if (state_q == wvs_pkg::S_MAC) begin
      if (u.last) begin
        acc_q <= init;
        case (u.comp)
          wvs_pkg::C_TW: tw_q <= res[34:0];
          wvs_pkg::C_TX: tx_q <= res[34:0];
          wvs_pkg::C_TY: ty_q <= res[34:0];
          wvs_pkg::C_TZ: tz_q <= res[34:0];
          wvs_pkg::C_RX: rx_q <= res[38:0];
          wvs_pkg::C_RY: ry_q <= res[38:0];
          wvs_pkg::C_RZ: rz_q <= res[38:0];
          wvs_pkg::C_AX: ax_q <= res[43:0];
          wvs_pkg::C_AY: ay_q <= res[43:0];
          wvs_pkg::C_AZ: az_q <= res[43:0];
          default: ;
        endcase
      end else begin
        acc_q <= sum;
      end
      if (step_q == wvs_pkg::LAST_STEP) begin
        widx_q <= widx_q + 10'd1;
        rem_q  <= rem_q - 5'd1;
      end
    end
    if (state_q == wvs_pkg::S_DONE && (!out_valid_o || !out_stall_i)) begin
      if (err_q) begin
        pos_x_o  <= '0;
        pos_y_o  <= '0;
        pos_z_o  <= '0;
        status_o <= wvs_pkg::ST_RANGE;
      end else begin
        pos_x_o  <= cx;
        pos_y_o  <= cy;
        pos_z_o  <= cz;
        status_o <= (sx || sy || sz) ? wvs_pkg::ST_SAT : wvs_pkg::ST_OK;
      end
    end
  end

endmodule

// File: rtl/wvs_ram.sv
// wvs_ram: generic single-clock RAM, one write port, one registered read port
// no dependencies
module wvs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/tb.sv
// tb: self-checking bench for weighted_vertex_skinning, with a queue-fed driver,
// an output monitor and an integer model of the skinning arithmetic
// depends on wvs_pkg and the weighted_vertex_skinning rtl
module tb;

  typedef struct {
    wvs_pkg::req_e kind;
    logic [9:0]  idx;
    logic [5:0]  jref;
    logic [4:0]  cnt;
    logic [31:0] vx, vy, vz;
    logic [15:0] qx, qy, qz, qw;
    logic [14:0] bias;
  } req_t;

  typedef struct {
    logic [31:0] px, py, pz;
    wvs_pkg::status_e st;
  } vtx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [9:0] entry_index_i = '0;
  logic [5:0] joint_ref_i = '0;
  logic [4:0] weight_count_i = '0;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic signed [15:0] rot_x_i = '0, rot_y_i = '0, rot_z_i = '0, rot_w_i = '0;
  logic [14:0] bias_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;
  logic [1:0] status_o;

  weighted_vertex_skinning dut (.*);

  always #6 clk_i = ~clk_i;

  req_t pending_reqs[$];
  vtx_t expected_vtx[$];
  int   accepted_reqs = 0;
  int   mismatches = 0;
  int   cycle_count = 0;

  // model tables
  logic [15:0] jt_q[wvs_pkg::JOINT_DEPTH][4];
  logic [31:0] jt_pos[wvs_pkg::JOINT_DEPTH][3];
  logic [31:0] wt_pos[wvs_pkg::WEIGHT_DEPTH][3];
  logic [14:0] wt_bias[wvs_pkg::WEIGHT_DEPTH];
  logic [5:0]  wt_joint[wvs_pkg::WEIGHT_DEPTH];

  // stimulus-side bookkeeping of what is written
  bit       gen_jset[wvs_pkg::JOINT_DEPTH];
  bit       gen_wset[wvs_pkg::WEIGHT_DEPTH];
  bit [5:0] gen_wjoint[wvs_pkg::WEIGHT_DEPTH];

  function automatic longint round14(longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic logic [31:0] clamp32(longint x, ref bit hit);
    if (x > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'h7fffffff;
    end
    if (x < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  function automatic void model_request(req_t r);
    vtx_t v;
    int n;
    longint ax, ay, az, px, py, pz, b, qx, qy, qz, qw;
    longint tw, tx, ty, tz, rx, ry, rz;
    bit hit;
    int wi;
    int j;
    case (r.kind)
      wvs_pkg::REQ_JOINT: begin
        if (r.idx < wvs_pkg::JOINT_DEPTH) begin
          jt_q[r.idx] = '{r.qx, r.qy, r.qz, r.qw};
          jt_pos[r.idx] = '{r.vx, r.vy, r.vz};
        end
      end
      wvs_pkg::REQ_WEIGHT: begin
        wt_pos[r.idx] = '{r.vx, r.vy, r.vz};
        wt_bias[r.idx] = r.bias;
        wt_joint[r.idx] = r.jref;
      end
      wvs_pkg::REQ_SKIN: begin
        n = (r.cnt > wvs_pkg::MAX_VERTEX_WEIGHTS) ? wvs_pkg::MAX_VERTEX_WEIGHTS : r.cnt;
        ax = 0; ay = 0; az = 0; hit = 1'b0;
        if (r.idx + n > wvs_pkg::WEIGHT_DEPTH) begin
          v = '{32'd0, 32'd0, 32'd0, wvs_pkg::ST_RANGE};
        end else begin
          for (int k = 0; k < n; k++) begin
            wi = r.idx + k;
            j = wt_joint[wi];
            px = $signed(wt_pos[wi][0]);
            py = $signed(wt_pos[wi][1]);
            pz = $signed(wt_pos[wi][2]);
            b = wt_bias[wi];
            qx = $signed(jt_q[j][0]);
            qy = $signed(jt_q[j][1]);
            qz = $signed(jt_q[j][2]);
            qw = $signed(jt_q[j][3]);
            tw = round14(-px * qx - py * qy - pz * qz);
            tx = round14(px * qw + py * qz - pz * qy);
            ty = round14(-px * qz + py * qw + pz * qx);
            tz = round14(px * qy - py * qx + pz * qw);
            rx = round14(qw * tx - qx * tw - qy * tz + qz * ty);
            ry = round14(qw * ty + qx * tz - qy * tw - qz * tx);
            rz = round14(qw * tz - qx * ty + qy * tx - qz * tw);
            ax += round14(($signed(jt_pos[j][0]) + rx) * b);
            ay += round14(($signed(jt_pos[j][1]) + ry) * b);
            az += round14(($signed(jt_pos[j][2]) + rz) * b);
          end
          v.px = clamp32(ax, hit);
          v.py = clamp32(ay, hit);
          v.pz = clamp32(az, hit);
          v.st = hit ? wvs_pkg::ST_SAT : wvs_pkg::ST_OK;
        end
        expected_vtx = {expected_vtx, v};
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_vec();
    case ($urandom_range(0, 9))
      0, 1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  function automatic logic [15:0] rand_rot();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
  endfunction

  function automatic void queue_req(req_t r);
    if (r.kind == wvs_pkg::REQ_JOINT && r.idx < wvs_pkg::JOINT_DEPTH) gen_jset[r.idx] = 1'b1;
    if (r.kind == wvs_pkg::REQ_WEIGHT) begin
      gen_wset[r.idx] = 1'b1;
      gen_wjoint[r.idx] = r.jref;
    end
    pending_reqs = {pending_reqs, r};
  endfunction

  function automatic bit skin_is_safe(int idx, int cnt);
    int n;
    n = (cnt > wvs_pkg::MAX_VERTEX_WEIGHTS) ? wvs_pkg::MAX_VERTEX_WEIGHTS : cnt;
    if (idx + n > wvs_pkg::WEIGHT_DEPTH) return 1'b1;
    for (int k = 0; k < n; k++)
      if (!gen_wset[idx + k] || !gen_jset[gen_wjoint[idx + k]]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic req_t blank_req(wvs_pkg::req_e kind, int idx);
    req_t r;
    r = '{kind, 10'(idx), 6'd0, 5'd0, 32'd0, 32'd0, 32'd0,
          16'd0, 16'd0, 16'd0, 16'd0, 15'd0};
    return r;
  endfunction

  function automatic int pick_weight_idx();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, wvs_pkg::WEIGHT_DEPTH - 1);
      1, 2, 3: return $urandom_range(1000, wvs_pkg::WEIGHT_DEPTH - 1);
      default: return $urandom_range(0, 39);
    endcase
  endfunction

  task automatic build_stimulus();
    req_t r;
    int idx, cnt, sel;
    bit ok;
    // directed: extremes, ignored requests, clamp, range error, saturation
    r = blank_req(wvs_pkg::REQ_JOINT, 0);
    r.qw = 16'd16384;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_JOINT, 1);
    r.vx = 32'h7fffffff; r.vy = 32'h80000000; r.vz = 32'h7fffffff;
    r.qw = 16'd16384;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_JOINT, 63);
    r.vx = 32'hffffffff; r.vy = 32'h0000ffff; r.vz = 32'hffff0000;
    r.qx = 16'h8000; r.qy = 16'h7fff; r.qz = 16'hffff; r.qw = 16'h8000;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_JOINT, 1023);
    r.qx = 16'h7fff;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_WEIGHT, 0);
    r.vx = 32'h00010000; r.vy = 32'hfffe0000; r.vz = 32'h00030000;
    r.bias = 15'd16384; r.jref = 6'd0;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_WEIGHT, 1);
    r.vx = 32'h7fffffff; r.vy = 32'h80000000; r.vz = 32'hffffffff;
    r.bias = 15'd16384; r.jref = 6'd63;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_WEIGHT, 2);
    r.bias = 15'd16384; r.jref = 6'd1;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_WEIGHT, 3);
    r.bias = 15'd16384; r.jref = 6'd1;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_WEIGHT, 1023);
    r.vx = 32'h12345678; r.bias = 15'd0; r.jref = 6'd63;
    queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 0);   r.cnt = 5'd2;  queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 2);   r.cnt = 5'd2;  queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 0);   r.cnt = 5'd4;  queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 0);   r.cnt = 5'd0;  queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 1023); r.cnt = 5'd1; queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 1023); r.cnt = 5'd2; queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 1020); r.cnt = 5'd31; queue_req(r);
    r = blank_req(wvs_pkg::REQ_SKIN, 1023); r.cnt = 5'd0; queue_req(r);
    r = blank_req(wvs_pkg::REQ_JOINT, 0);
    r.kind = wvs_pkg::req_e'(2'd3); r.cnt = 5'd31; r.jref = 6'd63;
    queue_req(r);
    // random
    for (int i = 0; i < 650; i++) begin
      r = blank_req(wvs_pkg::REQ_JOINT, 0);
      r.vx = rand_vec(); r.vy = rand_vec(); r.vz = rand_vec();
      r.qx = rand_rot(); r.qy = rand_rot(); r.qz = rand_rot(); r.qw = rand_rot();
      r.bias = 15'($urandom_range(0, 16384));
      r.jref = 6'($urandom());
      r.cnt = 5'($urandom());
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        r.kind = wvs_pkg::REQ_JOINT;
        r.idx = ($urandom_range(0, 9) == 0) ?
                10'($urandom_range(wvs_pkg::JOINT_DEPTH, 1023)) :
                10'($urandom_range(0, wvs_pkg::JOINT_DEPTH - 1));
      end else if (sel < 55) begin
        r.kind = wvs_pkg::REQ_WEIGHT;
        r.idx = 10'(pick_weight_idx());
        if ($urandom_range(0, 4) != 0) r.jref = 6'($urandom_range(0, 3));
      end else if (sel < 96) begin
        r.kind = wvs_pkg::REQ_SKIN;
        ok = 1'b0;
        for (int t = 0; t < 12 && !ok; t++) begin
          idx = pick_weight_idx();
          cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
          ok = skin_is_safe(idx, cnt);
        end
        if (!ok) begin
          idx = $urandom_range(0, 1023);
          cnt = 0;
        end
        r.idx = 10'(idx);
        r.cnt = 5'(cnt);
      end else begin
        r.kind = wvs_pkg::req_e'(2'd3);
        r.idx = 10'($urandom());
      end
      queue_req(r);
    end
  endtask

  function automatic void idle_pcts(output int send_pct, output int recv_pct);
    case ((accepted_reqs / 80) % 5)
      1: begin send_pct = 78; recv_pct = 0; end
      2: begin send_pct = 0; recv_pct = 78; end
      3: begin send_pct = 13; recv_pct = 13; end
      default: begin send_pct = 0; recv_pct = 0; end
    endcase
  endfunction

  // driver
  req_t cur_req;
  always @(posedge clk_i) begin
    int sp, rp;
    bit nxt_valid;
    req_t r;
    if (rst_ni) begin
      idle_pcts(sp, rp);
      nxt_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        model_request(cur_req);
        accepted_reqs++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_reqs.size() > 0 && $urandom_range(0, 99) >= sp) begin
        r = pending_reqs.pop_front();
        cur_req <= r;
        req_type_i <= r.kind;
        entry_index_i <= r.idx;
        joint_ref_i <= r.jref;
        weight_count_i <= r.cnt;
        vec_x_i <= r.vx; vec_y_i <= r.vy; vec_z_i <= r.vz;
        rot_x_i <= r.qx; rot_y_i <= r.qy; rot_z_i <= r.qz; rot_w_i <= r.qw;
        bias_i <= r.bias;
        nxt_valid = 1'b1;
      end
      in_valid_i <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    int sp, rp;
    vtx_t e;
    if (rst_ni) begin
      idle_pcts(sp, rp);
      if (out_valid_o && !out_stall_i) begin
        if (expected_vtx.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: pos %h %h %h status %0d",
                                         pos_x_o, pos_y_o, pos_z_o, status_o);
        end else begin
          e = expected_vtx.pop_front();
          if (pos_x_o !== e.px || pos_y_o !== e.py || pos_z_o !== e.pz || status_o !== e.st)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h st %0d, got %h %h %h st %0d",
                       e.px, e.py, e.pz, e.st, pos_x_o, pos_y_o, pos_z_o, status_o);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < rp);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_valid_i || expected_vtx.size() > 0)
      @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && expected_vtx.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/wvs_pkg.sv
rtl/wvs_ram.sv
rtl/weighted_vertex_skinning.sv
tb/tb.sv
